FILE: rtl/bpa_pkg.sv
// Shared types and constants for the bitmap page allocator.
`default_nettype none

package bpa_pkg;

    // Map geometry: MAP_WORDS words of WORD_BITS pages each.
    localparam int MAP_WORDS = 16;
    localparam int WORD_BITS = 32;

    // Fixed field widths of the request and response beats.
    localparam int KIND_W   = 2;
    localparam int PAGE_W   = 9;
    localparam int COUNT_W  = 10;
    localparam int STATUS_W = 2;

    // Request kinds.
    localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FREE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_INIT  = 2'd2;

    // Response status codes.
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_FREE  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_PAGE = 2'd2;

    // Configuration register indexes.
    localparam logic REG_FIRST_USABLE = 1'b0;
    localparam logic REG_PAGE_COUNT   = 1'b1;

    // Saturation point of the free page counter.
    localparam logic [COUNT_W-1:0] TOTAL_MAX = 10'd1023;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic set_nofree;
        logic set_bad;
        logic step;
        logic scan;
        logic alloc_wr;
        logic free_wr;
        logic init_wr;
        logic init_done;
        logic load_out;
    } bpa_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic total_zero;
        logic page_bad;
        logic seek_hit;
        logic word_last;
        logic scan_found;
        logic scan_empty;
        logic out_free;
    } bpa_sts_t;

endpackage

`default_nettype wire

FILE: rtl/bpa_ctrl.sv
// Request sequencer of the bitmap page allocator.
`default_nettype none

module bpa_ctrl
    import bpa_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [KIND_W-1:0] kind,
    input  wire bpa_sts_t          sts,
    output bpa_cmd_t               cmd
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_SCAN = 6'b000010,
        S_SEEK = 6'b000100,
        S_FWR  = 6'b001000,
        S_INIT = 6'b010000,
        S_RESP = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == S_IDLE);

    // Next state and command decode.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    unique case (kind)
                        KIND_ALLOC:
                        begin
                            if (sts.total_zero)
                            begin
                                cmd.set_nofree = 1'b1;
                                state_next     = S_RESP;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        KIND_FREE:
                        begin
                            if (sts.page_bad)
                            begin
                                cmd.set_bad = 1'b1;
                                state_next  = S_RESP;
                            end
                            else
                            begin
                                state_next = S_SEEK;
                            end
                        end
                        KIND_INIT:
                        begin
                            state_next = S_INIT;
                        end
                        default:
                        begin
                            state_next = S_RESP;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                cmd.step = 1'b1;
                if (sts.scan_found)
                begin
                    cmd.alloc_wr = 1'b1;
                    state_next   = S_RESP;
                end
                else if (sts.scan_empty)
                begin
                    cmd.set_nofree = 1'b1;
                    state_next     = S_RESP;
                end
            end
            S_SEEK:
            begin
                if (sts.seek_hit)
                begin
                    state_next = S_FWR;
                end
                else
                begin
                    cmd.step = 1'b1;
                end
            end
            S_FWR:
            begin
                cmd.free_wr = 1'b1;
                state_next  = S_RESP;
            end
            S_INIT:
            begin
                cmd.init_wr = 1'b1;
                cmd.step    = 1'b1;
                if (sts.word_last)
                begin
                    cmd.init_done = 1'b1;
                    state_next    = S_RESP;
                end
            end
            S_RESP:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/bpa_dp.sv
// Datapath of the bitmap page allocator: free map memory, counters and result register.
`default_nettype none

module bpa_dp
    import bpa_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic [PAGE_W-1:0]   page,
    input  wire logic [PAGE_W-1:0]   first_usable,
    input  wire logic [COUNT_W-1:0]  page_count,
    input  wire bpa_cmd_t            cmd,
    output bpa_sts_t                 sts,
    input  wire logic                out_ready,
    output logic                     out_valid,
    output logic [STATUS_W-1:0]      status,
    output logic [PAGE_W-1:0]        alloc_page,
    output logic [COUNT_W-1:0]       free_pages
);

    localparam int CAPACITY = MAP_WORDS * WORD_BITS;
    localparam int WB_W     = $clog2(WORD_BITS);
    localparam int W_W      = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int AW       = $clog2(CAPACITY + 1024);
    localparam logic [W_W-1:0] LAST_WORD = W_W'(MAP_WORDS - 1);
    localparam logic [AW-1:0]  CAP_A     = AW'(CAPACITY);
    localparam logic [AW-1:0]  WB_A      = AW'(WORD_BITS);

    // Free map storage; a word not yet written reads as all zero.
    logic [WORD_BITS-1:0] mem [MAP_WORDS];
    logic [MAP_WORDS-1:0] wvalid_reg;
    logic [MAP_WORDS-1:0] wvalid_next;

    logic [W_W-1:0]       w_reg, w_next;
    logic [AW-1:0]        base_reg, base_next;
    logic [PAGE_W-1:0]    page_reg, page_next;
    logic [COUNT_W-1:0]   total_reg, total_next;
    logic [STATUS_W-1:0]  st_reg, st_next;
    logic [PAGE_W-1:0]    given_reg, given_next;

    logic [WORD_BITS-1:0] q_reg;
    logic                 qv_reg;
    logic [W_W-1:0]       q_w_reg;
    logic [AW-1:0]        q_base_reg;
    logic                 q_vld_reg;

    logic                 out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]  out_st_reg;
    logic [PAGE_W-1:0]    out_page_reg;
    logic [COUNT_W-1:0]   out_total_reg;

    logic [AW-1:0]        limit_a;
    logic [COUNT_W-1:0]   limit;
    logic [AW-1:0]        first_a;
    logic [COUNT_W-1:0]   init_count;
    logic [WORD_BITS-1:0] q_data;
    logic [WORD_BITS-1:0] q_low;
    logic [WB_W-1:0]      q_idx;
    logic [AW-1:0]        alloc_pos;
    logic [AW-1:0]        page_a;
    logic [AW-1:0]        page_off;
    logic [WORD_BITS-1:0] init_mask;
    logic                 wr_en;
    logic [W_W-1:0]       wr_addr;
    logic [WORD_BITS-1:0] wr_data;

    // Encode a one-hot word into the index of its set bit.
    function automatic logic [WB_W-1:0] onehot_index(input logic [WORD_BITS-1:0] oh);
        logic [WB_W-1:0] idx;
        idx = '0;
        for (int k = 0; k < WB_W; k++)
        begin
            for (int b = 0; b < WORD_BITS; b++)
            begin
                idx[k] = idx[k] | (oh[b] & ((b >> k) & 1) == 1);
            end
        end
        return idx;
    endfunction

    // Effective page count, clipped to the map capacity.
    assign limit_a    = (AW'(page_count) > CAP_A) ? CAP_A : AW'(page_count);
    assign limit      = limit_a[COUNT_W-1:0];
    assign first_a    = AW'(first_usable);
    assign init_count = (AW'(first_usable) < limit_a) ?
                        COUNT_W'(limit_a - first_a) : '0;

    // Lowest free page in the word under inspection.
    assign q_data    = qv_reg ? q_reg : '0;
    assign q_low     = q_data & (~q_data + WORD_BITS'(1));
    assign q_idx     = onehot_index(q_low);
    assign alloc_pos = q_base_reg + AW'(q_idx);

    // Bit offset of the released page within its word.
    assign page_a   = AW'(page_reg);
    assign page_off = page_a - base_reg;

    // Pages of the current word that init marks free.
    always_comb
    begin
        logic [AW-1:0] pos;
        init_mask = '0;
        for (int b = 0; b < WORD_BITS; b++)
        begin
            pos          = base_reg + AW'(b);
            init_mask[b] = (pos >= first_a) && (pos < limit_a);
        end
    end

    // Status toward the controller.
    always_comb
    begin
        sts.total_zero = (total_reg == '0);
        sts.page_bad   = (COUNT_W'(page) >= limit);
        sts.seek_hit   = (page_a < (base_reg + WB_A));
        sts.word_last  = (w_reg == LAST_WORD);
        sts.scan_found = q_vld_reg && (q_data != '0);
        sts.scan_empty = q_vld_reg && (q_data == '0) && (q_w_reg == LAST_WORD);
        sts.out_free   = !out_valid_reg || out_ready;
    end

    // Map write port selection.
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = w_reg;
        wr_data = init_mask;
        priority if (cmd.init_wr)
        begin
            wr_en = 1'b1;
        end
        else if (cmd.alloc_wr)
        begin
            wr_en   = 1'b1;
            wr_addr = q_w_reg;
            wr_data = q_data & ~q_low;
        end
        else if (cmd.free_wr)
        begin
            wr_en   = 1'b1;
            wr_data = q_data | (WORD_BITS'(1) << page_off[WB_W-1:0]);
        end
    end

    // Map memory with registered read at the current word.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        q_reg      <= mem[w_reg];
        q_w_reg    <= w_reg;
        q_base_reg <= base_reg;
    end

    // Word walk, request fields, counter and pending result.
    always_comb
    begin
        w_next      = w_reg;
        base_next   = base_reg;
        page_next   = page_reg;
        total_next  = total_reg;
        st_next     = st_reg;
        given_next  = given_reg;
        wvalid_next = wvalid_reg;
        if (wr_en)
        begin
            wvalid_next[wr_addr] = 1'b1;
        end
        if (cmd.accept)
        begin
            w_next     = '0;
            base_next  = '0;
            page_next  = page;
            given_next = '0;
            st_next    = ST_OK;
        end
        else if (cmd.step && (w_reg != LAST_WORD))
        begin
            w_next    = w_reg + W_W'(1);
            base_next = base_reg + WB_A;
        end
        if (cmd.set_bad)
        begin
            st_next = ST_BAD_PAGE;
        end
        else if (cmd.set_nofree)
        begin
            st_next = ST_NO_FREE;
        end
        if (cmd.alloc_wr)
        begin
            given_next = alloc_pos[PAGE_W-1:0];
            total_next = total_reg - COUNT_W'(1);
        end
        if (cmd.free_wr && (total_reg != TOTAL_MAX))
        begin
            total_next = total_reg + COUNT_W'(1);
        end
        if (cmd.init_done)
        begin
            total_next = init_count;
        end
    end

    always_ff @(posedge clk)
    begin
        page_reg  <= page_next;
        st_reg    <= st_next;
        given_reg <= given_next;
        w_reg     <= w_next;
        base_reg  <= base_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wvalid_reg <= '0;
            total_reg  <= '0;
            q_vld_reg  <= 1'b0;
            qv_reg     <= 1'b0;
        end
        else
        begin
            wvalid_reg <= wvalid_next;
            total_reg  <= total_next;
            q_vld_reg  <= cmd.scan;
            qv_reg     <= wvalid_reg[w_reg];
        end
    end

    // Result register; holds a beat while the next request is taken.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_st_reg    <= st_reg;
            out_page_reg  <= given_reg;
            out_total_reg <= total_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = out_st_reg;
    assign alloc_page = out_page_reg;
    assign free_pages = out_total_reg;

endmodule

`default_nettype wire

FILE: rtl/bitmap_page_allocator_top.sv
// Top level of the bitmap page allocator: configuration registers and unit wiring.
`default_nettype none

// First-fit page allocator over a bitmap of MAP_WORDS words of WORD_BITS pages,
// one bit per page, set when the page is free, plus a count of free pages.
// Every request beat yields exactly one response beat. One request is worked at
// a time; the map sits in a memory with one registered read, so requests walk it
// one word per cycle. After accept, alloc scans words until it finds a free
// page or passes the last word; free steps to the page's word and sets the
// page's bit there; init writes every word of the map. Each then returns its
// result. Requests that answer at once (empty count, page out of range, unused
// kind) go straight from accept to result. The map needs no clearing pass
// after reset: per-word valid bits make unwritten words read as empty.
// Registers may be written only while idle.
module bitmap_page_allocator_top
    import bpa_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [KIND_W-1:0]   kind,
    input  wire logic [PAGE_W-1:0]   page,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [STATUS_W-1:0]      status,
    output logic [PAGE_W-1:0]        alloc_page,
    output logic [COUNT_W-1:0]       free_pages,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic                cfg_index,
    input  wire logic [COUNT_W-1:0]  cfg_data
);

    logic [PAGE_W-1:0]  first_usable_reg, first_usable_next;
    logic [COUNT_W-1:0] page_count_reg, page_count_next;
    bpa_cmd_t           cmd;
    bpa_sts_t           sts;

    assign cfg_ready = 1'b1;

    // Configuration register writes.
    always_comb
    begin
        first_usable_next = first_usable_reg;
        page_count_next   = page_count_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_FIRST_USABLE: first_usable_next = cfg_data[PAGE_W-1:0];
                REG_PAGE_COUNT:   page_count_next   = cfg_data;
                default:          page_count_next   = page_count_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_usable_reg <= PAGE_W'(1);
            page_count_reg   <= COUNT_W'(512);
        end
        else
        begin
            first_usable_reg <= first_usable_next;
            page_count_reg   <= page_count_next;
        end
    end

    // Request sequencer.
    bpa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .kind     (kind),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Map, counters and result register.
    bpa_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .page         (page),
        .first_usable (first_usable_reg),
        .page_count   (page_count_reg),
        .cmd          (cmd),
        .sts          (sts),
        .out_ready    (out_ready),
        .out_valid    (out_valid),
        .status       (status),
        .alloc_page   (alloc_page),
        .free_pages   (free_pages)
    );

endmodule

`default_nettype wire

FILE: bench/bitmap_page_allocator_top_test.sv
// Self-checking testbench for the bitmap page allocator top level.
`timescale 1ns / 1ps

module bitmap_page_allocator_top_test
    import bpa_pkg::*;
();

    localparam int PAGE_CAP = MAP_WORDS * WORD_BITS;
    localparam int CYCLE_LIMIT = 1000000;
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [PAGE_W-1:0] page;
    } page_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [PAGE_W-1:0] page;
        logic [COUNT_W-1:0] total;
    } page_resp_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [KIND_W-1:0] kind = '0;
    logic [PAGE_W-1:0] page = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [STATUS_W-1:0] status;
    logic [PAGE_W-1:0] alloc_page;
    logic [COUNT_W-1:0] free_pages;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic cfg_index = 1'b0;
    logic [COUNT_W-1:0] cfg_data = '0;

    // Local copy of the allocator state and its registers.
    logic [PAGE_CAP-1:0] free_bits = '0;
    logic [COUNT_W-1:0] free_count = '0;
    logic [PAGE_W-1:0] first_page = 9'd1;
    logic [COUNT_W-1:0] page_limit = 10'd512;

    page_req_t pending_reqs[$];
    page_resp_t expected_resps[$];
    int queued_count = 0;
    int taken_count = 0;
    int error_count = 0;
    int cycle_count = 0;
    bit req_fire = 0;
    bit resp_fire = 0;
    int src_wait = 0;
    int src_quiet = 0;
    int sink_wait = 0;
    int sink_quiet = 0;

    bitmap_page_allocator_top uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .kind(kind),
        .page(page),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .status(status),
        .alloc_page(alloc_page),
        .free_pages(free_pages),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #1 clk = ~clk;

    // Page count as the allocator sees it, clamped to the map size.
    function automatic int usable_limit();
        return (page_limit > PAGE_CAP) ? PAGE_CAP : int'(page_limit);
    endfunction

    // Applies one request to the local state and returns the response it causes.
    function automatic page_resp_t allocate_or_release(input logic [KIND_W-1:0] k,
                                                       input logic [PAGE_W-1:0] p);
        page_resp_t res;
        int lim;
        bit found;
        res.status = ST_OK;
        res.page = '0;
        lim = usable_limit();
        found = 0;
        case (k)
            KIND_ALLOC:
            begin
                if (free_count != 0)
                begin
                    for (int i = 0; i < PAGE_CAP && !found; i++)
                    begin
                        if (free_bits[i])
                        begin
                            free_bits[i] = 1'b0;
                            res.page = 9'(i);
                            free_count = free_count - 1'b1;
                            found = 1;
                        end
                    end
                end
                if (!found)
                begin
                    res.status = ST_NO_FREE;
                    res.page = '0;
                end
            end
            KIND_FREE:
            begin
                if (int'(p) >= lim)
                begin
                    res.status = ST_BAD_PAGE;
                end
                else
                begin
                    free_bits[p] = 1'b1;
                    if (free_count != TOTAL_MAX)
                        free_count = free_count + 1'b1;
                end
            end
            KIND_INIT:
            begin
                free_bits = '0;
                free_count = '0;
                for (int i = int'(first_page); i < lim; i++)
                begin
                    free_bits[i] = 1'b1;
                    free_count = free_count + 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        res.total = free_count;
        return res;
    endfunction

    // Pause length: mostly none or short, a few long, with quiet stretches.
    function automatic int pick_pause(inout int quiet);
        int roll;
        if (quiet > 0)
        begin
            quiet--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 2)
        begin
            quiet = $urandom_range(20, 80);
            return 0;
        end
        if (roll < 55)
            return 0;
        if (roll < 88)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic queue_req(input logic [KIND_W-1:0] k, input logic [PAGE_W-1:0] p);
        page_req_t r;
        r.kind = k;
        r.page = p;
        pending_reqs.push_back(r);
        queued_count++;
    endtask

    // Random phase: starts with an init, then mostly allocs and in-range frees.
    task automatic queue_random(input int n, input int free_pct);
        int lim;
        int roll;
        logic [KIND_W-1:0] k;
        logic [PAGE_W-1:0] p;
        lim = usable_limit();
        queue_req(KIND_INIT, 9'($urandom_range(0, PAGE_CAP - 1)));
        for (int i = 1; i < n; i++)
        begin
            roll = $urandom_range(0, 99);
            p = 9'($urandom_range(0, PAGE_CAP - 1));
            if (roll < free_pct)
            begin
                k = KIND_FREE;
                if (lim > 0 && $urandom_range(0, 9) < 8)
                    p = 9'($urandom_range(0, lim - 1));
            end
            else if (roll < 94)
                k = KIND_ALLOC;
            else if (roll < 97)
                k = KIND_INIT;
            else
                k = KIND_UNUSED;
            queue_req(k, p);
        end
    endtask

    // Register write through the configuration channel.
    task automatic write_reg(input logic idx, input logic [COUNT_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == REG_FIRST_USABLE)
            first_page = val[PAGE_W-1:0];
        else
            page_limit = val;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic write_both(input logic [COUNT_W-1:0] first, input logic [COUNT_W-1:0] cnt);
        write_reg(REG_FIRST_USABLE, first);
        write_reg(REG_PAGE_COUNT, cnt);
        @(posedge clk);
    endtask

    // Waits until every queued request is taken and every response is back.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (!(taken_count == queued_count && expected_resps.size() == 0));
        repeat (4) @(negedge clk);
    endtask

    // Request driver: a new beat is presented only once the previous one is taken.
    always @(negedge clk)
    begin
        if (rst_n && (req_fire || !in_valid))
        begin
            if (req_fire)
                src_wait = pick_pause(src_quiet);
            if (src_wait > 0)
            begin
                in_valid <= 1'b0;
                src_wait--;
            end
            else if (pending_reqs.size() > 0)
            begin
                page_req_t r;
                r = pending_reqs.pop_front();
                in_valid <= 1'b1;
                kind <= r.kind;
                page <= r.page;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Response sink: stalls after some beats and now and then while waiting.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (resp_fire)
                sink_wait = pick_pause(sink_quiet);
            else if (sink_wait == 0 && sink_quiet == 0 && $urandom_range(0, 19) == 0)
                sink_wait = $urandom_range(1, 4);
            if (sink_wait > 0)
            begin
                out_ready <= 1'b0;
                sink_wait--;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Monitor: predicts on each request beat and checks each response beat.
    always @(posedge clk)
    begin
        page_resp_t got;
        page_resp_t want;
        req_fire = rst_n && in_valid && in_ready;
        resp_fire = rst_n && out_valid && out_ready;
        if (req_fire)
        begin
            expected_resps.push_back(allocate_or_release(kind, page));
            taken_count++;
        end
        if (resp_fire)
        begin
            got.status = status;
            got.page = alloc_page;
            got.total = free_pages;
            if (expected_resps.size() == 0)
            begin
                error_count++;
                if (error_count <= 10)
                    $display("Unexpected response beat: status %0d page %0d free %0d",
                             got.status, got.page, got.total);
            end
            else
            begin
                want = expected_resps.pop_front();
                if (got !== want)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display("Mismatch: status %0d/%0d page %0d/%0d free %0d/%0d (exp/got)",
                                 want.status, got.status, want.page, got.page,
                                 want.total, got.total);
                end
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset registers: empty map, double free, count left without bits.
        queue_req(KIND_ALLOC, 9'd0);
        queue_req(KIND_UNUSED, 9'd511);
        queue_req(KIND_FREE, 9'd0);
        queue_req(KIND_ALLOC, 9'd0);
        queue_req(KIND_FREE, 9'd511);
        queue_req(KIND_FREE, 9'd511);
        queue_req(KIND_ALLOC, 9'd0);
        queue_req(KIND_ALLOC, 9'd0);
        queue_req(KIND_INIT, 9'd0);
        queue_req(KIND_ALLOC, 9'd511);
        queue_req(KIND_ALLOC, 9'd0);
        queue_req(KIND_FREE, 9'd1);
        queue_req(KIND_ALLOC, 9'd0);
        queue_req(KIND_FREE, 9'd0);
        queue_req(KIND_ALLOC, 9'd0);
        wait_drained();

        // No pages at all: every free is out of range.
        write_both(10'd0, 10'd0);
        queue_req(KIND_INIT, 9'd0);
        queue_req(KIND_FREE, 9'd0);
        queue_req(KIND_FREE, 9'd511);
        queue_req(KIND_ALLOC, 9'd0);
        wait_drained();

        // Oversized page count clamps to the map; one page left at the top.
        write_both(10'd511, 10'd1023);
        queue_req(KIND_INIT, 9'd0);
        queue_req(KIND_ALLOC, 9'd0);
        queue_req(KIND_ALLOC, 9'd0);
        queue_req(KIND_FREE, 9'd256);
        wait_drained();

        // Empty init range, then frees on either side of the page count.
        write_both(10'd5, 10'd5);
        queue_req(KIND_INIT, 9'd0);
        queue_req(KIND_FREE, 9'd4);
        queue_req(KIND_FREE, 9'd5);
        wait_drained();

        // Full map, free heavy, so double frees raise the free count above the page count.
        write_both(10'd0, 10'd512);
        queue_random(530, 90);
        wait_drained();

        // Small maps, alloc heavy, so the map runs dry often.
        for (int ph = 0; ph < 6; ph++)
        begin
            if (ph == 2)
                write_both(10'($urandom_range(480, 511)), 10'($urandom_range(513, 1023)));
            else
                write_both(10'($urandom_range(0, 40)), 10'($urandom_range(0, 96)));
            queue_random(85, 35);
            wait_drained();
        end

        repeat (40) @(posedge clk);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
